// ----- src/sa_pkg.sv -----
// shared types, constants and cipher functions for the s-aes pipeline
// no dependencies; imported by sa_cfg, sa_pass and the top level
package sa_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_KEY_ONE    = 2'd0;
  localparam logic [1:0] REG_KEY_TWO    = 2'd1;
  localparam logic [1:0] REG_KEY_THREE  = 2'd2;
  localparam logic [1:0] REG_PASS_COUNT = 2'd3;

  localparam logic [3:0] FWD_BOX [16] = '{
    4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
    4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
  };
  localparam logic [3:0] INV_BOX [16] = '{
    4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
    4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
  };

  localparam logic [7:0] RCON_ONE = 8'h80;
  localparam logic [7:0] RCON_TWO = 8'h30;

  typedef struct packed {
    logic        valid;
    logic        action;
    logic [15:0] block;
  } sa_stage_t;

  // multiply in gf(2^4) mod x^4+x+1
  function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] acc;
    logic [3:0] x;
    acc = 4'h0;
    x   = a;
    for (int k = 0; k < 4; k++) begin
      if (b[k]) acc = acc ^ x;
      x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
    end
    return acc;
  endfunction

  function automatic logic [15:0] sub_fwd(input logic [15:0] v);
    return {FWD_BOX[v[15:12]], FWD_BOX[v[11:8]], FWD_BOX[v[7:4]], FWD_BOX[v[3:0]]};
  endfunction

  function automatic logic [15:0] sub_inv(input logic [15:0] v);
    return {INV_BOX[v[15:12]], INV_BOX[v[11:8]], INV_BOX[v[7:4]], INV_BOX[v[3:0]]};
  endfunction

  // swap nibbles 1 and 3
  function automatic logic [15:0] swap_rows(input logic [15:0] v);
    return {v[15:12], v[3:0], v[7:4], v[11:8]};
  endfunction

  function automatic logic [15:0] mix(input logic [15:0] v, input logic [3:0] d,
                                      input logic [3:0] o);
    logic [3:0] m0, m1, m2, m3;
    m0 = gf_mul(d, v[15:12]) ^ gf_mul(o, v[11:8]);
    m1 = gf_mul(o, v[15:12]) ^ gf_mul(d, v[11:8]);
    m2 = gf_mul(d, v[7:4])   ^ gf_mul(o, v[3:0]);
    m3 = gf_mul(o, v[7:4])   ^ gf_mul(d, v[3:0]);
    return {m0, m1, m2, m3};
  endfunction

  function automatic logic [7:0] g_func(input logic [7:0] w, input logic [7:0] rc);
    logic [7:0] rot;
    rot = {w[3:0], w[7:4]};
    return {FWD_BOX[rot[7:4]], FWD_BOX[rot[3:0]]} ^ rc;
  endfunction

  // round keys one and two (round key zero is the key itself)
  function automatic logic [31:0] expand(input logic [15:0] key);
    logic [7:0] w2, w3, w4, w5;
    w2 = key[15:8] ^ g_func(key[7:0], RCON_ONE);
    w3 = w2 ^ key[7:0];
    w4 = w2 ^ g_func(w3, RCON_TWO);
    w5 = w4 ^ w3;
    return {w2, w3, w4, w5};
  endfunction

  function automatic logic [15:0] enc_pass(input logic [15:0] b, input logic [15:0] key);
    logic [31:0] rk;
    logic [15:0] t;
    rk = expand(key);
    t  = b ^ key;
    t  = mix(swap_rows(sub_fwd(t)), 4'h1, 4'h4);
    t  = t ^ rk[31:16];
    t  = swap_rows(sub_fwd(t));
    return t ^ rk[15:0];
  endfunction

  function automatic logic [15:0] dec_pass(input logic [15:0] b, input logic [15:0] key);
    logic [31:0] rk;
    logic [15:0] t;
    rk = expand(key);
    t  = b ^ rk[15:0];
    t  = sub_inv(swap_rows(t));
    t  = t ^ rk[31:16];
    t  = mix(t, 4'h9, 4'h2);
    t  = sub_inv(swap_rows(t));
    return t ^ key;
  endfunction

endpackage

// ----- src/sa_cfg.sv -----
// configuration register file: three keys and the pass count
// depends on sa_pkg for register indexes
module sa_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] key_one,
  output logic [15:0] key_two,
  output logic [15:0] key_three,
  output logic [1:0]  pass_count
);
  import sa_pkg::*;

  logic [1:0] reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_one    <= 16'h0000;
      key_two    <= 16'h0000;
      key_three  <= 16'h0000;
      pass_count <= 2'd1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_KEY_ONE:    key_one    <= pwdata[15:0];
        REG_KEY_TWO:    key_two    <= pwdata[15:0];
        REG_KEY_THREE:  key_three  <= pwdata[15:0];
        REG_PASS_COUNT: pass_count <= pwdata[1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY_ONE:    prdata = {16'h0000, key_one};
      REG_KEY_TWO:    prdata = {16'h0000, key_two};
      REG_KEY_THREE:  prdata = {16'h0000, key_three};
      REG_PASS_COUNT: prdata = {30'h0, pass_count};
      default:        prdata = 32'h0;
    endcase
  end

endmodule

// ----- src/sa_pass.sv -----
// one pipeline stage: a full two-round s-aes pass in either direction
// depends on sa_pkg for the stage struct and cipher functions
module sa_pass (
  input  logic              clk,
  input  logic              rst,
  input  sa_pkg::sa_stage_t stage_in,
  input  logic [15:0]       key,
  input  logic              active,
  output sa_pkg::sa_stage_t stage_out
);
  import sa_pkg::*;

  logic [15:0] block_next;

  // an inactive stage passes the item through untouched
  always_comb begin
    if (!active) begin
      block_next = stage_in.block;
    end else if (stage_in.action) begin
      block_next = dec_pass(stage_in.block, key);
    end else begin
      block_next = enc_pass(stage_in.block, key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else begin
      stage_out.valid <= stage_in.valid;
    end
    stage_out.action <= stage_in.action;
    stage_out.block  <= block_next;
  end

endmodule

// ----- src/simplified_aes_multi_cipher.sv -----
// s-aes with up to three chained passes: input register then one stage per pass
// the result strobe (done) is registered through the input register and the three pass stages
// throughput: one item per cycle, set by the pass stages; busy is high only in reset
// the receiver cannot stall, so results leave on done with no hold-off
// reset clears the pipeline valid bits, the keys to zero and the pass count to one
// depends on sa_pkg, sa_cfg and sa_pass
module simplified_aes_multi_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  input  logic        action,
  input  logic [15:0] block_in,
  output logic        busy,
  output logic        done,
  output logic [15:0] block_out
);
  import sa_pkg::*;

  logic [15:0] key_one, key_two, key_three;
  logic [1:0]  pass_count;
  logic        two_up, three_up;
  sa_stage_t   s0, s1, s2, s3;
  logic [15:0] key0, key2;
  logic        act0, act2;

  sa_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .key_one    (key_one),
    .key_two    (key_two),
    .key_three  (key_three),
    .pass_count (pass_count)
  );

  assign busy = rst;

  // pass count zero acts as one
  assign two_up   = pass_count[1];
  assign three_up = (pass_count == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
    end else begin
      s0.valid <= start && !busy;
    end
    s0.action <= action;
    s0.block  <= block_in;
  end

  // decryption walks the keys backward, so the outer stages swap keys
  assign key0 = s0.action ? key_three : key_one;
  assign act0 = s0.action ? three_up : 1'b1;
  assign key2 = s2.action ? key_one : key_three;
  assign act2 = s2.action ? 1'b1 : three_up;

  sa_pass u_pass0 (
    .clk (clk), .rst (rst), .stage_in (s0), .key (key0), .active (act0), .stage_out (s1)
  );

  sa_pass u_pass1 (
    .clk (clk), .rst (rst), .stage_in (s1), .key (key_two), .active (two_up),
    .stage_out (s2)
  );

  sa_pass u_pass2 (
    .clk (clk), .rst (rst), .stage_in (s2), .key (key2), .active (act2), .stage_out (s3)
  );

  assign done      = s3.valid;
  assign block_out = s3.block;

  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted item gave no result");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without an accepted item");

  a_valid_chain: assert property (@(posedge clk) disable iff (rst)
    (s2.valid == $past(s1.valid)) && (s3.valid == $past(s2.valid)))
    else $error("valid bit lost or invented between stages");

endmodule
